// ===== src/source_cooldown_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the source cooldown table
// The macros use clk, and SCT_ASSERT also rst_n, from the including module's scope.
// ----------------------------------------------------------------------------
`ifndef SOURCE_COOLDOWN_TABLE_MACROS_SVH
`define SOURCE_COOLDOWN_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset
`define SCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define SCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCT_ASSERT(lbl, prop, msg)
`define SCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Shared constants, codes and result type of the source cooldown table.
// ----------------------------------------------------------------------------
package sct_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int FUNC_W  = 2;
    localparam int SRC_W   = 32;
    localparam int TIME_W  = 48;
    localparam int REM_W   = 26;
    localparam int CD_W    = 16;
    localparam int CDMS_W  = 26;
    localparam int ENTRY_W = SRC_W + TIME_W;

    // constants
    localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] REMAIN_MAX     = TIME_W'(65535000);
    localparam logic [CDMS_W-1:0] MS_PER_S       = CDMS_W'(1000);
    localparam logic [CD_W-1:0]   COOLDOWN_RESET = CD_W'(300);

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // one response
    typedef struct packed {
        logic              act;
        logic [REM_W-1:0]  rem;
        logic              ev;
        logic [SRC_W-1:0]  es;
        logic [TIME_W-1:0] ee;
        logic              full;
        logic              last;
    } sct_result_t;

endpackage

// ===== src/sct_if.sv =====
// ----------------------------------------------------------------------------
// Channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sct_req_if;
    import sct_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SRC_W-1:0]  src_id;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, func, src_id, now_ms, input ready);
    modport sink   (input valid, func, src_id, now_ms, output ready);
endinterface

interface sct_rsp_if;
    import sct_pkg::*;
    logic              valid;
    logic              ready;
    logic              cooldown_active;
    logic [REM_W-1:0]  remaining_ms;
    logic              entry_valid;
    logic [SRC_W-1:0]  entry_source;
    logic [TIME_W-1:0] entry_expiry_ms;
    logic              table_full;
    logic              last;

    modport source (output valid, cooldown_active, remaining_ms, entry_valid, entry_source,
                    entry_expiry_ms, table_full, last, input ready);
    modport sink   (input valid, cooldown_active, remaining_ms, entry_valid, entry_source,
                    entry_expiry_ms, table_full, last, output ready);
endinterface

interface sct_cfg_if;
    import sct_pkg::*;
    logic            valid;
    logic            ready;
    logic [CD_W-1:0] cd_seconds;

    modport source (output valid, cd_seconds, input ready);
    modport sink   (input valid, cd_seconds, output ready);
endinterface

// ===== src/sct_ram.sv =====
// ----------------------------------------------------------------------------
// sct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/sct_outreg.sv =====
// ----------------------------------------------------------------------------
// sct_outreg
// Response output register: decouples the engine from a stalling receiver.
// ----------------------------------------------------------------------------
module sct_outreg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sct_pkg::sct_result_t result,
    output logic                 out_free,
    sct_rsp_if.source            rsp
);
    import sct_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    sct_result_t res_reg;

    // slot is free when empty or when the held response is taken this cycle
    assign out_free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= result;
        end
    end

    assign rsp.valid           = valid_reg;
    assign rsp.cooldown_active = res_reg.act;
    assign rsp.remaining_ms    = res_reg.rem;
    assign rsp.entry_valid     = res_reg.ev;
    assign rsp.entry_source    = res_reg.es;
    assign rsp.entry_expiry_ms = res_reg.ee;
    assign rsp.table_full      = res_reg.full;
    assign rsp.last            = res_reg.last;

endmodule

// ===== src/sct_engine.sv =====
// ----------------------------------------------------------------------------
// sct_engine
// Request sequencer: scans the slot RAM, evaluates each slot, writes back on a record.
// ----------------------------------------------------------------------------
`include "source_cooldown_table_macros.svh"

module sct_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    sct_req_if.sink                     req,
    input  logic [sct_pkg::CDMS_W-1:0]  cd_ms,
    input  logic                        out_free,
    output logic                        push,
    output sct_pkg::sct_result_t        result
);
    import sct_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // control state
    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   dv_reg, dv_next;
    logic [IDX_W-1:0]       ev_idx_reg, ev_idx_next;
    logic                   hit_reg, hit_next;
    logic                   free_reg, free_next;
    logic                   pend_reg, pend_next;
    logic [RES_CNT_W-1:0]   lcnt_reg, lcnt_next;
    logic [TABLE_DEPTH-1:0] slot_valid_reg, slot_valid_next;

    // payload state
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [SRC_W-1:0]       src_reg, src_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [CDMS_W-1:0]      cdms_reg, cdms_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [TIME_W-1:0]      hit_exp_reg, hit_exp_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [SRC_W-1:0]       pend_src_reg, pend_src_next;
    logic [TIME_W-1:0]      pend_exp_reg, pend_exp_next;

    // RAM ports
    logic                   ram_re;
    logic                   ram_we;
    logic [IDX_W-1:0]       wr_idx;
    logic [ENTRY_W-1:0]     wr_data;
    logic [ENTRY_W-1:0]     rd_data;

    // slot evaluation
    logic [SRC_W-1:0]       cur_src;
    logic [TIME_W-1:0]      cur_exp;
    logic                   cur_vld;
    logic                   cur_match;
    logic                   cur_live;
    logic                   cur_free;
    logic                   list_take;
    logic                   stall;
    logic                   scan_more;

    // done-phase arithmetic
    logic [TIME_W:0]        exp_sum;
    logic [TIME_W-1:0]      exp_new;
    logic [TIME_W-1:0]      rem_diff;
    logic                   chk_active;

    // phase flags for the checks below
    logic                   in_list_scan;
    logic                   in_record_done;

    sct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (ram_re),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign req.ready = (state_reg == ST_IDLE);

    // current slot, from the registered read data of the slot RAM
    assign cur_src   = rd_data[ENTRY_W-1:TIME_W];
    assign cur_exp   = rd_data[TIME_W-1:0];
    assign cur_vld   = dv_reg && slot_valid_reg[ev_idx_reg];
    assign cur_match = cur_vld && (cur_src == src_reg);
    assign cur_live  = cur_vld && (cur_exp > now_reg);
    assign cur_free  = dv_reg && !cur_live;
    assign list_take = (func_reg == FUNC_LIST) && cur_live
                       && (lcnt_reg < RES_CNT_W'(MAX_RESULTS));
    assign stall     = list_take && pend_reg && !out_free;
    assign scan_more = (rd_cnt_reg < CNT_W'(TABLE_DEPTH));

    // new expiry, saturated
    assign exp_sum = {1'b0, now_reg} + (TIME_W + 1)'(cdms_reg);
    assign exp_new = exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];

    // check result
    assign chk_active = hit_reg && (hit_exp_reg > now_reg);
    assign rem_diff   = hit_exp_reg - now_reg;

    assign wr_idx  = hit_reg ? hit_idx_reg : free_idx_reg;
    assign wr_data = {src_reg, exp_new};

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        rd_cnt_next     = rd_cnt_reg;
        dv_next         = dv_reg;
        ev_idx_next     = ev_idx_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        pend_next       = pend_reg;
        lcnt_next       = lcnt_reg;
        slot_valid_next = slot_valid_reg;
        func_next       = func_reg;
        src_next        = src_reg;
        now_next        = now_reg;
        cdms_next       = cdms_reg;
        hit_idx_next    = hit_idx_reg;
        hit_exp_next    = hit_exp_reg;
        free_idx_next   = free_idx_reg;
        pend_src_next   = pend_src_reg;
        pend_exp_next   = pend_exp_reg;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        push            = 1'b0;
        result          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next   = req.func;
                    src_next    = req.src_id;
                    now_next    = req.now_ms;
                    cdms_next   = cd_ms;
                    rd_cnt_next = '0;
                    dv_next     = 1'b0;
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    pend_next   = 1'b0;
                    lcnt_next   = '0;
                    // unused code: dropped without a response
                    if (req.func != FUNC_NONE)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    // evaluate the slot held in the registered read data
                    if (cur_match && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = ev_idx_reg;
                        hit_exp_next = cur_exp;
                    end
                    if (cur_free && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = ev_idx_reg;
                    end
                    if (list_take)
                    begin
                        // flush the held entry, it is not the final one
                        if (pend_reg)
                        begin
                            push      = 1'b1;
                            result.ev = 1'b1;
                            result.es = pend_src_reg;
                            result.ee = pend_exp_reg;
                        end
                        pend_next     = 1'b1;
                        pend_src_next = cur_src;
                        pend_exp_next = cur_exp;
                        lcnt_next     = lcnt_reg + RES_CNT_W'(1);
                    end
                    // issue the next read
                    ram_re      = scan_more;
                    dv_next     = scan_more;
                    ev_idx_next = rd_cnt_reg[IDX_W-1:0];
                    if (scan_more)
                    begin
                        rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    push        = 1'b1;
                    result.last = 1'b1;
                    state_next  = ST_IDLE;
                    priority if (func_reg == FUNC_RECORD)
                    begin
                        if (hit_reg || free_reg)
                        begin
                            ram_we                  = 1'b1;
                            slot_valid_next[wr_idx] = 1'b1;
                        end
                        else
                        begin
                            result.full = 1'b1;
                        end
                    end
                    else if (func_reg == FUNC_CHECK)
                    begin
                        result.act = chk_active;
                        if (chk_active)
                        begin
                            result.rem = (rem_diff > REMAIN_MAX) ? REM_W'(REMAIN_MAX)
                                                                 : rem_diff[REM_W-1:0];
                        end
                    end
                    else
                    begin
                        // list: final held entry, or the empty marker
                        result.ev = pend_reg;
                        result.es = pend_reg ? pend_src_reg : '0;
                        result.ee = pend_reg ? pend_exp_reg : '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            dv_reg         <= 1'b0;
            ev_idx_reg     <= '0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            lcnt_reg       <= '0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            dv_reg         <= dv_next;
            ev_idx_reg     <= ev_idx_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            pend_reg       <= pend_next;
            lcnt_reg       <= lcnt_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        src_reg      <= src_next;
        now_reg      <= now_next;
        cdms_reg     <= cdms_next;
        hit_idx_reg  <= hit_idx_next;
        hit_exp_reg  <= hit_exp_next;
        free_idx_reg <= free_idx_next;
        pend_src_reg <= pend_src_next;
        pend_exp_reg <= pend_exp_next;
    end

    // assertions
    assign in_list_scan   = (state_reg == ST_SCAN) && (func_reg == FUNC_LIST);
    assign in_record_done = (state_reg == ST_DONE) && (func_reg == FUNC_RECORD);

    `SCT_ASSERT(a_push_room, push |-> out_free, "response pushed into a full output register")
    `SCT_ASSERT(a_mid_list, (push && !result.last) |-> in_list_scan, "stray non-final response")
    `SCT_ASSERT(a_we_record, ram_we |-> in_record_done, "slot written outside a record")
    `SCT_ASSERT(a_we_valid, ram_we |=> slot_valid_reg[$past(wr_idx)], "written slot not valid")
    `SCT_ASSERT_ALWAYS(a_no_rw, !(ram_we && ram_re), "slot RAM read and written in one cycle")

endmodule

// ===== src/source_cooldown_table.sv =====
// ----------------------------------------------------------------------------
// source_cooldown_table
// Table of source IDs with cooldown expiry times: record, check and list.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per handshake (func, src_id, now_ms). func 0 records
//          a source, 1 checks it, 2 lists active entries, 3 is dropped.
//   rsp  : record and check give one response; list gives one response per
//          active slot in slot order, or one empty response, last on the final.
//   cfg  : cooldown length write in seconds, always ready; write only while idle.
// Flow: a request scans all TABLE_DEPTH slots of the slot RAM, one read per
//   cycle while the scan is not stalled, then gives its final response. One
//   request is worked on at a time; the next is taken as soon as the final
//   response sits in the output register.
// Reset: valid flags clear at once and cooldown returns to 300 s; no clearing
//   pass, requests are taken right after reset.
// Stall: a held response waits in the output register; a list scan pauses
//   while an earlier entry cannot be handed over.
// ----------------------------------------------------------------------------
module source_cooldown_table (
    input  logic       clk,
    input  logic       rst_n,
    sct_cfg_if.sink    cfg,
    sct_req_if.sink    req,
    sct_rsp_if.source  rsp
);
    import sct_pkg::*;

    logic [CD_W-1:0]   cooldown_reg;
    logic [CD_W-1:0]   cooldown_next;
    logic [CDMS_W-1:0] cd_ms;
    logic              push;
    logic              out_free;
    sct_result_t       result;

    // configuration register
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cooldown_next = cooldown_reg;
        if (cfg.valid)
        begin
            cooldown_next = cfg.cd_seconds;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_reg <= COOLDOWN_RESET;
        end
        else
        begin
            cooldown_reg <= cooldown_next;
        end
    end

    // cooldown in milliseconds, registered by the engine at acceptance
    assign cd_ms = CDMS_W'(cooldown_reg) * MS_PER_S;

    sct_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cd_ms    (cd_ms),
        .out_free (out_free),
        .push     (push),
        .result   (result)
    );

    sct_outreg u_outreg (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .result   (result),
        .out_free (out_free),
        .rsp      (rsp)
    );

endmodule
